@@ rtl/core/half_shell_neighbor_cells_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the half-shell neighbor cell walker
// Shared helpers that clock on clk_i and, where asked, ignore reset.
// ----------------------------------------------------------------------------
`ifndef HALF_SHELL_NEIGHBOR_CELLS_CORE_ASSERT_SVH
`define HALF_SHELL_NEIGHBOR_CELLS_CORE_ASSERT_SVH

// checked only while out of reset
`define HSNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HSNC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/hsnc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsnc_pkg
// Types, constants and the neighbor offset table of the cell walker.
// ----------------------------------------------------------------------------
package hsnc_pkg;

  localparam int MAX_DIM  = 32;
  localparam int DIM_W    = 6;              // holds 1..MAX_DIM
  localparam int POS_W    = 5;              // holds 0..MAX_DIM-1
  localparam int NXY_W    = 11;             // holds MAX_DIM*MAX_DIM
  localparam int IDX_W    = 15;
  localparam int DELTA_W  = 13;             // signed linear offset of a neighbor
  localparam int NUM_OFF  = 14;
  localparam int K_W      = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

  localparam logic signed [1:0] P = 2'sb01;
  localparam logic signed [1:0] Z = 2'sb00;
  localparam logic signed [1:0] M = 2'sb11;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } off_t;

  // self first, then the 13 half-shell neighbors
  localparam off_t OFF_TAB [NUM_OFF] = '{
    '{Z, Z, Z}, '{P, Z, Z}, '{Z, P, Z}, '{Z, Z, P},
    '{P, P, Z}, '{P, Z, P}, '{Z, P, P}, '{P, M, Z},
    '{M, Z, P}, '{Z, M, P}, '{P, P, P}, '{M, P, P},
    '{P, M, P}, '{M, M, P}
  };

  typedef struct packed {
    logic [DIM_W-1:0] nx;
    logic [DIM_W-1:0] ny;
    logic [DIM_W-1:0] nz;
    logic [NXY_W-1:0] nxy;
  } dims_t;

  typedef struct packed {
    logic [IDX_W-1:0]   home;
    logic [NUM_OFF-1:0] mask;
    logic               last_cell;
  } cell_t;

endpackage

@@ rtl/core/hsnc_intf.sv @@
// ----------------------------------------------------------------------------
// hsnc request and result channels
// Valid/ready channels; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface hsnc_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface hsnc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [hsnc_pkg::IDX_W-1:0]  cell_index;
  logic [hsnc_pkg::IDX_W-1:0]  neighbor_index;
  logic                        last_of_cell;
  logic                        last_cell;

  modport source (output valid, output cell_index, output neighbor_index,
                  output last_of_cell, output last_cell, input ready);
  modport sink   (input valid, input cell_index, input neighbor_index,
                  input last_of_cell, input last_cell, output ready);
endinterface

@@ rtl/core/hsnc_walker.sv @@
// ----------------------------------------------------------------------------
// hsnc_walker
// Holds the walk position, builds the home cell and its neighbor mask on
// each request transfer and steps to the next cell in x-fastest order.
// ----------------------------------------------------------------------------
module hsnc_walker (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsnc_req_if.sink       req,
  input  hsnc_pkg::dims_t dims_i,
  input  logic           take_i,
  output logic           load_o,
  output hsnc_pkg::cell_t cell_o
);
  import hsnc_pkg::*;

  logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [POS_W-1:0] pos_x_d, pos_y_d, pos_z_d;
  logic [POS_W-1:0] cx, cy, cz;
  logic             out_of_grid;
  logic             x_hi, y_hi, z_hi, x_lo, y_lo, z_lo;
  logic [15:0]      z_term;
  logic [NXY_W-1:0] y_term;

  function automatic logic axis_ok(input logic signed [1:0] d, input logic lo,
                                   input logic hi);
    logic r;
    r = 1'b1;
    if (d == P) r = hi;
    else if (d == M) r = lo;
    return r;
  endfunction

  assign req.ready = take_i;
  assign load_o    = req.valid && take_i;

  assign out_of_grid = ({1'b0, pos_x_q} >= dims_i.nx) || ({1'b0, pos_y_q} >= dims_i.ny) ||
                       ({1'b0, pos_z_q} >= dims_i.nz);

  always_comb begin
    if (req.restart || out_of_grid) begin
      cx = '0;
      cy = '0;
      cz = '0;
    end else begin
      cx = pos_x_q;
      cy = pos_y_q;
      cz = pos_z_q;
    end
  end

  assign x_hi = ({1'b0, cx} + DIM_W'(1)) < dims_i.nx;
  assign y_hi = ({1'b0, cy} + DIM_W'(1)) < dims_i.ny;
  assign z_hi = ({1'b0, cz} + DIM_W'(1)) < dims_i.nz;
  assign x_lo = cx != '0;
  assign y_lo = cy != '0;
  assign z_lo = cz != '0;

  assign z_term = 16'(cz) * 16'(dims_i.nxy);
  assign y_term = NXY_W'(cy) * NXY_W'(dims_i.nx);

  always_comb begin
    cell_o.home      = IDX_W'(z_term + 16'(y_term) + 16'(cx));
    cell_o.last_cell = !x_hi && !y_hi && !z_hi;
    for (int k = 0; k < NUM_OFF; k++) begin
      cell_o.mask[k] = axis_ok(OFF_TAB[k].dx, x_lo, x_hi) &&
                       axis_ok(OFF_TAB[k].dy, y_lo, y_hi) &&
                       axis_ok(OFF_TAB[k].dz, z_lo, z_hi);
    end
  end

  always_comb begin
    pos_x_d = '0;
    pos_y_d = '0;
    pos_z_d = '0;
    if (x_hi) begin
      pos_x_d = cx + POS_W'(1);
      pos_y_d = cy;
      pos_z_d = cz;
    end else if (y_hi) begin
      pos_y_d = cy + POS_W'(1);
      pos_z_d = cz;
    end else if (z_hi) begin
      pos_z_d = cz + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (load_o) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

endmodule

@@ rtl/core/hsnc_emitter.sv @@
// ----------------------------------------------------------------------------
// hsnc_emitter
// Holds one cell and sends its in-grid neighbors, one result per cycle
// while rsp.ready is high, through a registered result stage.
// ----------------------------------------------------------------------------
`include "half_shell_neighbor_cells_core_assert.svh"

module hsnc_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hsnc_pkg::dims_t dims_i,
  input  logic            load_i,
  input  hsnc_pkg::cell_t cell_i,
  output logic            take_o,
  hsnc_rsp_if.source      rsp
);
  import hsnc_pkg::*;

  logic                 cell_valid_q, cell_valid_d;
  logic [NUM_OFF-1:0]   mask_q, mask_d;
  logic [IDX_W-1:0]     home_q;
  logic                 last_cell_q;
  logic                 out_valid_q, out_valid_d;
  logic [IDX_W-1:0]     cell_index_q, neighbor_index_q;
  logic                 last_of_cell_q, last_cell_out_q;

  logic                 out_load, adv, last;
  logic [NUM_OFF-1:0]   sel, rest;
  logic [K_W-1:0]       k;
  logic signed [DELTA_W-1:0] delta;
  logic [15:0]          nb_sum;

  function automatic logic signed [DELTA_W-1:0] term(input logic signed [1:0] d,
                                                     input logic [NXY_W-1:0] step);
    logic signed [DELTA_W-1:0] t;
    t = '0;
    unique case (d)
      P:       t = $signed(DELTA_W'(step));
      M:       t = -$signed(DELTA_W'(step));
      default: t = '0;
    endcase
    return t;
  endfunction

  assign out_load = !out_valid_q || rsp.ready;
  assign adv      = cell_valid_q && out_load;

  // lowest pending offset first
  assign sel  = mask_q & (~mask_q + NUM_OFF'(1));
  assign rest = mask_q & ~sel;
  assign last = rest == '0;

  always_comb begin
    k = '0;
    for (int i = 0; i < NUM_OFF; i++) begin
      if (sel[i]) k = k | K_W'(i);
    end
  end

  assign delta = term(OFF_TAB[k].dx, NXY_W'(1)) + term(OFF_TAB[k].dy, NXY_W'(dims_i.nx)) +
                 term(OFF_TAB[k].dz, dims_i.nxy);
  assign nb_sum = {1'b0, home_q} + 16'($signed(delta));

  assign take_o = !cell_valid_q || (adv && last);

  always_comb begin
    cell_valid_d = cell_valid_q;
    mask_d       = mask_q;
    if (take_o) begin
      cell_valid_d = load_i;
      mask_d       = cell_i.mask;
    end else if (adv) begin
      mask_d = rest;
    end
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cell_valid_q <= cell_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    if (take_o && load_i) begin
      home_q      <= cell_i.home;
      last_cell_q <= cell_i.last_cell;
    end
    if (adv) begin
      cell_index_q     <= home_q;
      neighbor_index_q <= nb_sum[IDX_W-1:0];
      last_of_cell_q   <= last;
      last_cell_out_q  <= last_cell_q;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.cell_index     = cell_index_q;
  assign rsp.neighbor_index = neighbor_index_q;
  assign rsp.last_of_cell   = last_of_cell_q;
  assign rsp.last_cell      = last_cell_out_q;

  `HSNC_ASSERT(a_mask_nonempty, cell_valid_q |-> (mask_q != '0), "held cell has no offset left")
  `HSNC_ASSERT(a_take_on_last, (load_i && cell_valid_q) |-> (adv && last), "cell dropped early")
  `HSNC_ASSERT(a_self_first, (load_i && take_o) |=> (cell_valid_q && mask_q[0]), "self missing")
  `HSNC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!cell_valid_q && !out_valid_q), "busy in reset")

endmodule

@@ rtl/core/half_shell_neighbor_cells_core.sv @@
// ----------------------------------------------------------------------------
// half_shell_neighbor_cells_core
// Half-shell neighbor cell walker over a configurable 3D cell grid.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one restart bit per transfer; restart=1 starts at cell 0,
//   otherwise the next cell in x-fastest order is taken (wrapping after
//   the final cell). For each request transfer rsp sends 1 to 14 results:
//   the home cell itself, then its in-grid half-shell neighbors in fixed
//   order, last_of_cell marking the final one and last_cell the grid's
//   final home cell.
//   The first result passes the held-cell registers and then the output
//   register; a low rsp.ready can stall it between them. One result
//   leaves per cycle while rsp.ready is high, up to 14 per cell, as set
//   by the held cell's pending-offset mask; the next request is taken as
//   its predecessor's last result enters the output register.
//   Grid sizes are written on cfg_* while no work is pending; they reset
//   to 1. Reset clears the position and empties the pipeline.
//   When rsp.ready is low the result holds and the emitter stalls; a new
//   request waits until the current cell has issued its last result.
// ----------------------------------------------------------------------------
module half_shell_neighbor_cells_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hsnc_req_if.sink                         req,
  hsnc_rsp_if.source                       rsp,
  input  logic                             cfg_we_i,
  input  logic [hsnc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsnc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hsnc_pkg::*;

  logic [DIM_W-1:0] grid_x_q, grid_y_q, grid_z_q;
  dims_t            dims;
  cell_t            walk_cell;
  logic             load, take;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= DIM_W'(1);
      grid_y_q <= DIM_W'(1);
      grid_z_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_X: grid_x_q <= cfg_data_i;
        CFG_GRID_Y: grid_y_q <= cfg_data_i;
        CFG_GRID_Z: grid_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.nx  = eff_dim(grid_x_q);
    dims.ny  = eff_dim(grid_y_q);
    dims.nz  = eff_dim(grid_z_q);
    dims.nxy = NXY_W'(dims.nx) * NXY_W'(dims.ny);
  end

  hsnc_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .dims_i (dims),
    .take_i (take),
    .load_o (load),
    .cell_o (walk_cell)
  );

  hsnc_emitter u_emitter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dims_i (dims),
    .load_i (load),
    .cell_i (walk_cell),
    .take_o (take),
    .rsp    (rsp)
  );

endmodule
